/* rtl/rle_palette_sprite_decoder_unit_assert.svh */
// Assertion macros used by the sprite decoder top level.
`ifndef RLE_PALETTE_SPRITE_DECODER_UNIT_ASSERT_SVH
`define RLE_PALETTE_SPRITE_DECODER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked on every clock edge outside reset.
`define RPSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define RPSD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPSD_ASSERT(label, prop, msg)
`define RPSD_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* rtl/rpsd_pkg.sv */
// Types, constants and a helper function for the run-length sprite decoder.
package rpsd_pkg;

  localparam int PALETTE_ENTRIES = 16;
  localparam int ADDRESS_BITS    = 20;
  localparam int PAL_IDX_W       = $clog2(PALETTE_ENTRIES);
  localparam int PIXEL_ADDR_W    = 20;
  localparam int FRAME_WIDTH_W   = 10;
  localparam int COLUMN_W        = 9;

  localparam logic [FRAME_WIDTH_W-1:0] FRAME_WIDTH_RESET = 10'd240;

  localparam logic [1:0] OP_PALETTE = 2'd0;
  localparam logic [1:0] OP_HEADER  = 2'd1;
  localparam logic [1:0] OP_RUN     = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic pal_write;
    logic hdr_write;
    logic run_load;
    logic pix_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic run_nonzero;
    logic last_step;
    logic emit;
    logic out_free;
  } status_t;

  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

/* rtl/rle_palette_sprite_decoder_unit.sv */
// Top level of the run-length palette sprite decoder.
//
// Input items arrive on in_valid/in_stall; a request is taken when in_valid is
// high and in_stall low. Palette and header items are taken without a stall
// and give no pixel writes. A code byte with a non-zero run of 1 to 15 pixels
// holds the input stalled while the single pixel stepper advances the column
// and row base once a cycle, unless a write waiting downstream holds the step.
// Pixel writes leave on out_valid/out_stall from an output register; the first
// follows the run load and the first step. While the receiver stalls,
// the current write holds and the run pauses; skipped pixels do not wait.
// A new item is taken while the last write of a run still waits downstream.
// frame_width is written on cfg_valid/cfg_ready; ready is always high and
// the user must make writes only while the block is idle; the block does not enforce it.
// Synchronous reset empties the output register, returns to idle, clears the
// palette and sprite state and sets frame_width to 240.
`include "rle_palette_sprite_decoder_unit_assert.svh"
module rle_palette_sprite_decoder_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         opcode,
  input  logic [3:0]                         entry_index,
  input  logic [7:0]                         red,
  input  logic [7:0]                         green,
  input  logic [7:0]                         blue,
  input  logic                               flame_mode,
  input  logic [7:0]                         x_origin,
  input  logic [7:0]                         y_origin,
  input  logic [7:0]                         sprite_width,
  input  logic [7:0]                         code_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rpsd_pkg::PIXEL_ADDR_W-1:0]  pixel_address,
  output logic [15:0]                        pixel_color,
  output logic [7:0]                         pixel_alpha,
  output logic                               blend,
  output logic                               last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rpsd_pkg::FRAME_WIDTH_W-1:0] cfg_data
);

  rpsd_pkg::cmd_t    cmd;
  rpsd_pkg::status_t status;

  assign cfg_ready = 1'b1;

  rpsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  rpsd_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .entry_index   (entry_index),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .flame_mode    (flame_mode),
    .x_origin      (x_origin),
    .y_origin      (y_origin),
    .sprite_width  (sprite_width),
    .code_byte     (code_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .pixel_alpha   (pixel_alpha),
    .blend         (blend),
    .last          (last)
  );

  `RPSD_ASSERT(a_run_busy, (in_valid && !in_stall && opcode == rpsd_pkg::OP_RUN && code_byte[7:4] != 4'd0) |=> in_stall, "run request did not make the block busy")
  `RPSD_ASSERT(a_write_from_run, $rose(out_valid) |-> $past(in_stall), "pixel write appeared outside a run")
  `RPSD_ASSERT(a_mid_run_busy, (out_valid && !last) |-> in_stall, "block idle before the last write of a run")
  `RPSD_ASSERT_ALWAYS(a_reset_clears, rst |=> (!out_valid && !in_stall), "reset left the block busy")

endmodule

/* rtl/rpsd_ctrl.sv */
// Controller state machine: item intake and pixel stepping of a run.
module rpsd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       opcode,
  input  rpsd_pkg::status_t status,
  output logic             in_stall,
  output rpsd_pkg::cmd_t   cmd
);

  rpsd_pkg::state_t state;
  rpsd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpsd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rpsd_pkg::ST_IDLE: begin
        if (in_valid && opcode == rpsd_pkg::OP_RUN && status.run_nonzero) begin
          state_next = rpsd_pkg::ST_RUN;
        end
      end
      rpsd_pkg::ST_RUN: begin
        if ((!status.emit || status.out_free) && status.last_step) begin
          state_next = rpsd_pkg::ST_IDLE;
        end
      end
      default: state_next = rpsd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    cmd.pal_write = 1'b0;
    cmd.hdr_write = 1'b0;
    cmd.run_load  = 1'b0;
    cmd.pix_step  = 1'b0;
    case (state)
      rpsd_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.pal_write = in_valid && opcode == rpsd_pkg::OP_PALETTE;
        cmd.hdr_write = in_valid && opcode == rpsd_pkg::OP_HEADER;
        cmd.run_load  = in_valid && opcode == rpsd_pkg::OP_RUN && status.run_nonzero;
      end
      rpsd_pkg::ST_RUN: begin
        // A skipped pixel never waits for the output register.
        cmd.pix_step = !status.emit || status.out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

/* rtl/rpsd_datapath.sv */
// Datapath: frame width, palette, sprite position state, run counter and output register.
module rpsd_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  rpsd_pkg::cmd_t                     cmd,
  output rpsd_pkg::status_t                  status,
  input  logic                               cfg_valid,
  input  logic [rpsd_pkg::FRAME_WIDTH_W-1:0] cfg_data,
  input  logic [3:0]                         entry_index,
  input  logic [7:0]                         red,
  input  logic [7:0]                         green,
  input  logic [7:0]                         blue,
  input  logic                               flame_mode,
  input  logic [7:0]                         x_origin,
  input  logic [7:0]                         y_origin,
  input  logic [7:0]                         sprite_width,
  input  logic [7:0]                         code_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rpsd_pkg::PIXEL_ADDR_W-1:0]  pixel_address,
  output logic [15:0]                        pixel_color,
  output logic [7:0]                         pixel_alpha,
  output logic                               blend,
  output logic                               last
);

  localparam int AW = rpsd_pkg::ADDRESS_BITS;
  localparam int CW = rpsd_pkg::COLUMN_W;

  logic [rpsd_pkg::FRAME_WIDTH_W-1:0] frame_width;
  logic [15:0]                        palette_color [rpsd_pkg::PALETTE_ENTRIES];
  logic [7:0]                         palette_alpha [rpsd_pkg::PALETTE_ENTRIES];
  logic [AW-1:0]                      row_base;
  logic [CW-1:0]                      column;
  logic [7:0]                         row_length;
  logic                               blend_mode;
  logic [3:0]                         remaining;
  logic                               run_emit;
  logic [15:0]                        run_color;
  logic [7:0]                         run_alpha;

  logic [15:0]   new_color;
  logic [7:0]    new_alpha;
  logic [17:0]   hdr_prod;
  logic [18:0]   hdr_sum;
  logic [3:0]    code_idx;
  logic          col_wrap;
  logic [CW-1:0] col_adj;
  logic [AW-1:0] base_adj;
  logic [AW-1:0] pix_addr;

  always_comb begin
    if (flame_mode) begin
      new_alpha = green;
      if (green > 8'd127) begin
        new_color = rpsd_pkg::pack565(8'd255 - green, green, green);
      end else begin
        new_color = rpsd_pkg::pack565(8'd255, 8'd0, 8'd0);
      end
    end else begin
      new_alpha = 8'd255;
      new_color = rpsd_pkg::pack565(red, green, blue);
    end
  end

  assign hdr_prod = y_origin * frame_width;
  assign hdr_sum  = {1'b0, hdr_prod} + 19'(x_origin);
  assign code_idx = code_byte[3:0];

  // Wrap to the next sprite row before the pixel is placed.
  assign col_wrap = column >= {1'b0, row_length};
  assign col_adj  = col_wrap ? column - {1'b0, row_length} : column;
  assign base_adj = col_wrap ? AW'(row_base + AW'(frame_width)) : row_base;
  assign pix_addr = AW'(base_adj + AW'(col_adj));

  assign status.run_nonzero = code_byte[7:4] != 4'd0;
  assign status.last_step   = remaining == 4'd1;
  assign status.emit        = run_emit;
  assign status.out_free    = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= rpsd_pkg::FRAME_WIDTH_RESET;
    end else if (cfg_valid) begin
      frame_width <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rpsd_pkg::PALETTE_ENTRIES; i++) begin
        palette_color[i] <= '0;
        palette_alpha[i] <= '0;
      end
    end else if (cmd.pal_write && 32'(entry_index) < rpsd_pkg::PALETTE_ENTRIES) begin
      palette_color[entry_index[rpsd_pkg::PAL_IDX_W-1:0]] <= new_color;
      palette_alpha[entry_index[rpsd_pkg::PAL_IDX_W-1:0]] <= new_alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_base   <= '0;
      column     <= '0;
      row_length <= 8'd1;
      blend_mode <= 1'b0;
      remaining  <= '0;
      run_emit   <= 1'b0;
    end else if (cmd.hdr_write) begin
      row_base   <= AW'(hdr_sum);
      column     <= '0;
      row_length <= (sprite_width == 8'd0) ? 8'd1 : sprite_width;
      blend_mode <= flame_mode;
    end else if (cmd.run_load) begin
      remaining <= code_byte[7:4];
      run_emit  <= code_idx != 4'd0;
    end else if (cmd.pix_step) begin
      row_base  <= base_adj;
      column    <= col_adj + CW'(1);
      remaining <= remaining - 4'd1;
    end
  end

  // The run's colour is latched once; the palette cannot change during a run.
  always_ff @(posedge clk) begin
    if (cmd.run_load) begin
      if (32'(code_idx) < rpsd_pkg::PALETTE_ENTRIES) begin
        run_color <= palette_color[code_idx[rpsd_pkg::PAL_IDX_W-1:0]];
        run_alpha <= palette_alpha[code_idx[rpsd_pkg::PAL_IDX_W-1:0]];
      end else begin
        run_color <= '0;
        run_alpha <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.pix_step && run_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_step && run_emit) begin
      pixel_address <= rpsd_pkg::PIXEL_ADDR_W'(pix_addr);
      pixel_color   <= run_color;
      pixel_alpha   <= blend_mode ? run_alpha : 8'd255;
      blend         <= blend_mode;
      last          <= remaining == 4'd1;
    end
  end

endmodule
